/* rtl/core/hsf_pkg.sv */
// ----------------------------------------------------------------------------
// hsf_pkg
// shared constants for the horn-schunck flow iteration block
// ----------------------------------------------------------------------------
package hsf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int LINE_LEN   = MAX_WIDTH + 2;
   localparam int ADDR_W     = $clog2(LINE_LEN);

   localparam int PIX_W  = 8;
   localparam int FLOW_W = 20;
   localparam int GEOM_W = 11;
   localparam int POS_W  = 10;
   localparam int ALPHA_W = 24;
   localparam int CSR_IDX_W = 3;

   localparam int GRAD_W = 12;   // gradient sums
   localparam int SUM_W  = 24;   // weighted flow sums
   localparam int GSQ_W  = 24;   // squared gradient
   localparam int GS_W   = 36;   // gradient times flow sum
   localparam int P_W    = 37;
   localparam int Q_W    = 28;
   localparam int SQ_W   = 52;
   localparam int GP_W   = 49;
   localparam int NUM_W  = 56;   // signed dividend
   localparam int MAG_W  = NUM_W - 1;
   localparam int DEN_W  = 33;
   localparam int CNT_W  = $clog2(MAG_W + 1);
   localparam int LINE_W = 2 * PIX_W + 4 * FLOW_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd4;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 24'd163;

   typedef logic signed [FLOW_W-1:0] flow_type;

endpackage

/* rtl/core/horn_schunck_flow_iteration.sv */
// ----------------------------------------------------------------------------
// horn_schunck_flow_iteration
// one horn-schunck flow update over a padded raster frame
// ----------------------------------------------------------------------------
// One request is one padded pixel. A border request (padded row or column
// below 2) gives no response. Any other request passes through a line
// memory read, four arithmetic stages, then one shared restoring divider
// that works one quotient bit a cycle, first for the x flow and then for
// the y flow. The response sits in an output register, so the next request
// is taken while it waits.
module horn_schunck_flow_iteration (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [hsf_pkg::PIX_W-1:0]        req_first_intensity,
   input  logic [hsf_pkg::PIX_W-1:0]        req_second_intensity,
   input  logic signed [hsf_pkg::FLOW_W-1:0] req_flow_x_in,
   input  logic signed [hsf_pkg::FLOW_W-1:0] req_flow_y_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [hsf_pkg::FLOW_W-1:0] rsp_flow_x_out,
   output logic signed [hsf_pkg::FLOW_W-1:0] rsp_flow_y_out,
   output logic [hsf_pkg::POS_W-1:0]        rsp_out_row,
   output logic [hsf_pkg::POS_W-1:0]        rsp_out_col,
   output logic                             rsp_frame_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hsf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsf_pkg::ALPHA_W-1:0]      csr_data
);

   localparam int FW = hsf_pkg::FLOW_W;
   localparam int NW = hsf_pkg::NUM_W;
   localparam int MW = hsf_pkg::MAG_W;
   localparam int DW = hsf_pkg::DEN_W;
   localparam int GW = hsf_pkg::GEOM_W;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_READ = 4'd1;
   localparam logic [3:0] ST_MUL1 = 4'd2;
   localparam logic [3:0] ST_SUM  = 4'd3;
   localparam logic [3:0] ST_MUL2 = 4'd4;
   localparam logic [3:0] ST_NUM  = 4'd5;
   localparam logic [3:0] ST_DIVX = 4'd6;
   localparam logic [3:0] ST_DIVY = 4'd7;
   localparam logic [3:0] ST_FIN  = 4'd8;

   // configuration
   logic [hsf_pkg::ALPHA_W-1:0] alpha_ff;
   logic                        mode_ff;
   logic                        clip_ff;
   logic [GW-1:0]               width_ff;
   logic [GW-1:0]               height_ff;

   logic [3:0]    state_ff, state_in;
   logic [GW-1:0] row_ff, col_ff;
   logic [GW-1:0] wsize, hsize, wp, hp, pr_use, pc_use, pc_inc, pr_inc;
   logic          accept, csr_wr, geom_wr;

   // request capture
   logic [hsf_pkg::PIX_W-1:0] e0c_ff, e1c_ff;
   logic signed [FW-1:0]      fxc_ff, fyc_ff;
   logic [GW-1:0]             item_pr_ff, item_pc_ff;
   logic                      emit_ff, last_ff;

   // line memory and windows
   logic [hsf_pkg::LINE_W-1:0] line_mem [0:hsf_pkg::LINE_LEN-1];
   logic [hsf_pkg::LINE_W-1:0] mem_q_ff;
   logic [hsf_pkg::PIX_W-1:0]  iw_ff [0:3];
   logic signed [FW-1:0]       fw_ff [0:11];

   logic [hsf_pkg::PIX_W-1:0] e0u, e1u;
   logic signed [FW-1:0]      fxa, fxb, fya, fyb;

   // arithmetic
   logic signed [hsf_pkg::GRAD_W-1:0] gx_in, gy_in, gt_in, gx_ff, gy_ff, gt_ff;
   logic signed [hsf_pkg::SUM_W-1:0]  sx_in, sy_in, sx_ff, sy_ff;
   logic signed [hsf_pkg::GS_W-1:0]   gxsx_ff, gysy_ff;
   logic signed [hsf_pkg::GSQ_W-1:0]  gx2_ff, gy2_ff;
   logic signed [hsf_pkg::P_W-1:0]    p_in, p_ff, gtd;
   logic signed [hsf_pkg::Q_W-1:0]    q_in, q_ff;
   logic signed [hsf_pkg::SQ_W-1:0]   sxq_ff, syq_ff;
   logic signed [hsf_pkg::GP_W-1:0]   gxp_ff, gyp_ff;
   logic signed [NW-1:0]              dq, nx_in, ny_in, ny_ff, dsmall;
   logic [DW-1:0]                     den_in, den_ff;

   // divider
   logic [MW-1:0]  div_num_ff, div_num_in;
   logic [DW-1:0]  div_rem_ff, div_rem_in;
   logic [DW:0]    rem_sh;
   logic           rem_ge;
   logic           div_neg_ff;
   logic [hsf_pkg::CNT_W-1:0] div_cnt_ff;
   logic           div_done;
   logic signed [NW-1:0] q_signed, qx_ff;
   logic [MW-1:0]  ny_mag;

   // finish
   logic signed [NW-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [FW-1:0] out_x, out_y;
   logic                 out_free;

   logic                 rsp_valid_ff;
   logic signed [FW-1:0] rsp_fx_ff, rsp_fy_ff;
   logic [hsf_pkg::POS_W-1:0] rsp_row_ff, rsp_col_ff;
   logic                 rsp_last_ff;

   function automatic logic signed [FW-1:0] sat_clip(
      input logic signed [NW-1:0] v,
      input logic                 clip,
      input logic signed [NW-1:0] lo,
      input logic signed [NW-1:0] hi
   );
      logic signed [NW-1:0] t;
      t = v;
      if (clip && t < lo) t = lo;
      if (clip && t > hi) t = hi;
      if (t < NW'(-524288)) t = NW'(-524288);
      if (t > NW'(524287)) t = NW'(524287);
      return t[FW-1:0];
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign geom_wr   = csr_wr && (csr_index == hsf_pkg::CSR_WIDTH ||
                                 csr_index == hsf_pkg::CSR_HEIGHT);

   // geometry in use
   always_comb begin
      if (width_ff == '0) wsize = GW'(1);
      else if (width_ff > GW'(hsf_pkg::MAX_WIDTH)) wsize = GW'(hsf_pkg::MAX_WIDTH);
      else wsize = width_ff;
      if (height_ff == '0) hsize = GW'(1);
      else if (height_ff > GW'(hsf_pkg::MAX_HEIGHT)) hsize = GW'(hsf_pkg::MAX_HEIGHT);
      else hsize = height_ff;
      wp = wsize + GW'(2);
      hp = hsize + GW'(2);
      pc_use = (col_ff >= wp) ? '0 : col_ff;
      pr_use = (row_ff >= hp) ? '0 : row_ff;
      pc_inc = pc_use + GW'(1);
      pr_inc = pr_use + GW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= hsf_pkg::ALPHA_RESET;
         mode_ff   <= 1'b0;
         clip_ff   <= 1'b0;
         width_ff  <= GW'(hsf_pkg::MAX_WIDTH);
         height_ff <= GW'(hsf_pkg::MAX_HEIGHT);
      end else if (csr_wr) begin
         case (csr_index)
            hsf_pkg::CSR_ALPHA:  alpha_ff  <= csr_data;
            hsf_pkg::CSR_MODE:   mode_ff   <= csr_data[0];
            hsf_pkg::CSR_CLIP:   clip_ff   <= csr_data[0];
            hsf_pkg::CSR_WIDTH:  width_ff  <= csr_data[GW-1:0];
            hsf_pkg::CSR_HEIGHT: height_ff <= csr_data[GW-1:0];
            default: ;
         endcase
      end
   end

   // position counters
   always_ff @(posedge clock) begin
      if (reset || geom_wr) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         if (pc_inc >= wp) begin
            col_ff <= '0;
            row_ff <= (pr_inc >= hp) ? '0 : pr_inc;
         end else begin
            col_ff <= pc_inc;
            row_ff <= pr_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         e0c_ff     <= req_first_intensity;
         e1c_ff     <= req_second_intensity;
         fxc_ff     <= req_flow_x_in;
         fyc_ff     <= req_flow_y_in;
         item_pr_ff <= pr_use;
         item_pc_ff <= pc_use;
         emit_ff    <= (pr_use >= GW'(2)) && (pc_use >= GW'(2));
         last_ff    <= (pr_use == hp - GW'(1)) && (pc_use == wp - GW'(1));
      end
   end

   // line memory: {first, second, flow x upper, flow x lower, flow y upper, flow y lower}
   always_ff @(posedge clock) begin
      if (accept) mem_q_ff <= line_mem[pc_use];
      if (state_ff == ST_READ) begin
         line_mem[item_pc_ff] <= {e0c_ff, e1c_ff, fxb, fxc_ff, fyb, fyc_ff};
      end
   end

   assign e0u = mem_q_ff[hsf_pkg::LINE_W-1 -: 8];
   assign e1u = mem_q_ff[hsf_pkg::LINE_W-9 -: 8];
   assign fxa = mem_q_ff[4*FW-1 -: FW];
   assign fxb = mem_q_ff[3*FW-1 -: FW];
   assign fya = mem_q_ff[2*FW-1 -: FW];
   assign fyb = mem_q_ff[FW-1:0];

   // window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) iw_ff[i] <= '0;
         for (int i = 0; i < 12; i++) fw_ff[i] <= '0;
      end else if (state_ff == ST_READ) begin
         iw_ff[0] <= e0u;
         iw_ff[1] <= e0c_ff;
         iw_ff[2] <= e1u;
         iw_ff[3] <= e1c_ff;
         fw_ff[0] <= fw_ff[3];
         fw_ff[1] <= fw_ff[4];
         fw_ff[2] <= fw_ff[5];
         fw_ff[3] <= fxa;
         fw_ff[4] <= fxb;
         fw_ff[5] <= fxc_ff;
         fw_ff[6] <= fw_ff[9];
         fw_ff[7] <= fw_ff[10];
         fw_ff[8] <= fw_ff[11];
         fw_ff[9] <= fya;
         fw_ff[10] <= fyb;
         fw_ff[11] <= fyc_ff;
      end
   end

   // gradients and flow sums
   always_comb begin
      logic [9:0] a, b;
      a = 10'(iw_ff[1]) + 10'(e0c_ff) + 10'(iw_ff[3]) + 10'(e1c_ff);
      b = 10'(iw_ff[0]) + 10'(e0u) + 10'(iw_ff[2]) + 10'(e1u);
      gy_in = $signed({2'b00, a}) - $signed({2'b00, b});
      a = 10'(e0u) + 10'(e0c_ff) + 10'(e1u) + 10'(e1c_ff);
      b = 10'(iw_ff[0]) + 10'(iw_ff[1]) + 10'(iw_ff[2]) + 10'(iw_ff[3]);
      gx_in = $signed({2'b00, a}) - $signed({2'b00, b});
      a = 10'(iw_ff[2]) + 10'(e1u) + 10'(iw_ff[3]) + 10'(e1c_ff);
      b = 10'(iw_ff[0]) + 10'(e0u) + 10'(iw_ff[1]) + 10'(e0c_ff);
      gt_in = $signed({2'b00, a}) - $signed({2'b00, b});
      sx_in = (24'(fw_ff[0]) + 24'(fxa) + 24'(fw_ff[2]) + 24'(fxc_ff))
            + ((24'(fw_ff[3]) + 24'(fw_ff[1]) + 24'(fxb) + 24'(fw_ff[5])) <<< 1)
            + (mode_ff ? (24'(fw_ff[4]) <<< 2) : 24'sd0);
      sy_in = (24'(fw_ff[6]) + 24'(fya) + 24'(fw_ff[8]) + 24'(fyc_ff))
            + ((24'(fw_ff[9]) + 24'(fw_ff[7]) + 24'(fyb) + 24'(fw_ff[11])) <<< 1)
            + (mode_ff ? (24'(fw_ff[10]) <<< 2) : 24'sd0);
   end

   always_comb begin
      gtd  = mode_ff ? (37'(gt_ff) <<< 4) : ((37'(gt_ff) <<< 3) + (37'(gt_ff) <<< 2));
      p_in = 37'(gxsx_ff) + 37'(gysy_ff) + (gtd <<< 8);
      q_in = $signed({4'b0000, alpha_ff}) + ((28'(gx2_ff) + 28'(gy2_ff)) <<< 4);
      dq   = mode_ff ? (NW'(q_ff) <<< 4) : ((NW'(q_ff) <<< 3) + (NW'(q_ff) <<< 2));
      dsmall = mode_ff ? NW'(16) : NW'(12);
      if (q_ff == '0) begin
         nx_in  = (NW'(sx_ff) <<< 1) + dsmall;
         ny_in  = (NW'(sy_ff) <<< 1) + dsmall;
         den_in = DW'(dsmall <<< 1);
      end else begin
         nx_in  = ((NW'(sxq_ff) - (NW'(gxp_ff) <<< 4)) <<< 1) + dq;
         ny_in  = ((NW'(syq_ff) - (NW'(gyp_ff) <<< 4)) <<< 1) + dq;
         den_in = DW'(dq <<< 1);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_READ: begin
            gx_ff <= gx_in;
            gy_ff <= gy_in;
            gt_ff <= gt_in;
            sx_ff <= sx_in;
            sy_ff <= sy_in;
         end
         ST_MUL1: begin
            gxsx_ff <= 36'(gx_ff) * 36'(sx_ff);
            gysy_ff <= 36'(gy_ff) * 36'(sy_ff);
            gx2_ff  <= 24'(gx_ff) * 24'(gx_ff);
            gy2_ff  <= 24'(gy_ff) * 24'(gy_ff);
         end
         ST_SUM: begin
            p_ff <= p_in;
            q_ff <= q_in;
         end
         ST_MUL2: begin
            sxq_ff <= 52'(sx_ff) * 52'(q_ff);
            syq_ff <= 52'(sy_ff) * 52'(q_ff);
            gxp_ff <= 49'(gx_ff) * 49'(p_ff);
            gyp_ff <= 49'(gy_ff) * 49'(p_ff);
         end
         ST_NUM: begin
            ny_ff  <= ny_in;
            den_ff <= den_in;
         end
         default: ;
      endcase
   end

   // restoring divider, floor semantics through the one's complement of the dividend
   assign rem_sh   = {div_rem_ff, div_num_ff[MW-1]};
   assign rem_ge   = rem_sh >= {1'b0, den_ff};
   assign div_done = (div_cnt_ff == hsf_pkg::CNT_W'(MW - 1));
   assign q_signed = div_neg_ff ? ~{1'b0, div_num_in} : {1'b0, div_num_in};
   assign ny_mag   = ny_ff[NW-1] ? ~ny_ff[MW-1:0] : ny_ff[MW-1:0];

   always_comb begin
      div_rem_in = rem_ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
      div_num_in = {div_num_ff[MW-2:0], rem_ge};
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_NUM) begin
         div_num_ff <= nx_in[NW-1] ? ~nx_in[MW-1:0] : nx_in[MW-1:0];
         div_neg_ff <= nx_in[NW-1];
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (state_ff == ST_DIVX && div_done) begin
         qx_ff      <= q_signed;
         div_num_ff <= ny_mag;
         div_neg_ff <= ny_ff[NW-1];
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (state_ff == ST_DIVX || (state_ff == ST_DIVY && !div_done)) begin
         div_num_ff <= div_num_in;
         div_rem_ff <= div_rem_in;
         div_cnt_ff <= div_cnt_ff + hsf_pkg::CNT_W'(1);
      end else if (state_ff == ST_DIVY) begin
         div_num_ff <= div_num_in;
         div_rem_ff <= div_rem_in;
      end
   end

   // clip bounds and saturation
   always_comb begin
      lo_x = -(NW'(item_pc_ff - GW'(2)) <<< 8);
      hi_x = NW'($signed({1'b0, wsize}) - $signed({1'b0, item_pc_ff - GW'(2)})) <<< 8;
      lo_y = -(NW'(item_pr_ff - GW'(2)) <<< 8);
      hi_y = NW'($signed({1'b0, hsize}) - $signed({1'b0, item_pr_ff - GW'(2)})) <<< 8;
      out_x = sat_clip(qx_ff, clip_ff, lo_x, hi_x);
      out_y = sat_clip({div_neg_ff, div_num_ff} ^ {NW{div_neg_ff}} ^
                       {div_neg_ff, {MW{1'b0}}}, clip_ff, lo_y, hi_y);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = emit_ff ? ST_MUL1 : ST_IDLE;
         ST_MUL1: state_in = ST_SUM;
         ST_SUM:  state_in = ST_MUL2;
         ST_MUL2: state_in = ST_NUM;
         ST_NUM:  state_in = ST_DIVX;
         ST_DIVX: if (div_done) state_in = ST_DIVY;
         ST_DIVY: if (div_done) state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FIN && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && out_free) begin
         rsp_fx_ff   <= out_x;
         rsp_fy_ff   <= out_y;
         rsp_row_ff  <= hsf_pkg::POS_W'(item_pr_ff - GW'(2));
         rsp_col_ff  <= hsf_pkg::POS_W'(item_pc_ff - GW'(2));
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_flow_x_out = rsp_fx_ff;
   assign rsp_flow_y_out = rsp_fy_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_frame_last = rsp_last_ff;

   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("accepted request did not start a memory read");

   a_border_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && !emit_ff) |=> state_ff == ST_IDLE)
      else $error("border request did not return to idle");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && !out_free) |=> state_ff == ST_FIN)
      else $error("result dropped while output register busy");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVX || state_ff == ST_DIVY) |-> div_cnt_ff < hsf_pkg::CNT_W'(MW))
      else $error("divider step count out of range");

endmodule
